@@ rtl/slew_limited_servo_pwm_core_macros.svh @@
// assertion macros for the servo pwm core
`ifndef SLEW_LIMITED_SERVO_PWM_CORE_MACROS_SVH
`define SLEW_LIMITED_SERVO_PWM_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// plain property checked every clock outside reset
`define SLPWM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("slpwm assertion failed");
// overlapping implication checked every clock outside reset
`define SLPWM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("slpwm implication failed");
// next-cycle implication checked every clock outside reset
`define SLPWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("slpwm next-cycle implication failed");
`else
`define SLPWM_ASSERT(lbl, clk, rst_n, prop)
`define SLPWM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SLPWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/slpwm_pkg.sv @@
// shared types, constants and helpers for the servo pwm core
`timescale 1ns / 1ps
package slpwm_pkg;

  localparam int unsigned CHANNELS_DEF = 2;

  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned THRUST_W = 16;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned LEVELS_W = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [PERIOD_W-1:0] RST_PERIOD = 16'd4000;
  localparam logic [WIDTH_W-1:0]  RST_STEP   = 11'd8;
  localparam logic [WIDTH_W-1:0]  RST_MIN    = 11'd1000;
  localparam logic [WIDTH_W-1:0]  RST_MAX    = 11'd2000;
  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 11'd1400;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_SET_ONE = 2'd1,
    MODE_SET_ALL = 2'd2,
    MODE_STOP    = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD    = 2'd0,
    CFG_MAX_STEP  = 2'd1,
    CFG_PULSE_MIN = 2'd2,
    CFG_PULSE_MAX = 2'd3
  } cfg_idx_e;

  // per-channel control from the core
  typedef struct packed {
    logic               set_tgt;
    logic               ramp;
    logic [WIDTH_W-1:0] tgt;
  } chan_ctrl_t;

  // truncating remainder by 2048 (sign follows thrust), then clamped
  function automatic logic [WIDTH_W-1:0] make_target(
    input logic [THRUST_W-1:0] thrust,
    input logic [WIDTH_W-1:0]  pmin,
    input logic [WIDTH_W-1:0]  pmax
  );
    logic signed [WIDTH_W:0] rem;
    logic signed [WIDTH_W:0] lo;
    logic signed [WIDTH_W:0] hi;
    logic signed [WIDTH_W:0] r;
    if (thrust[THRUST_W-1] && (thrust[WIDTH_W-1:0] != '0)) begin
      rem = {1'b1, thrust[WIDTH_W-1:0]};
    end else begin
      rem = {1'b0, thrust[WIDTH_W-1:0]};
    end
    lo = {1'b0, pmin};
    hi = {1'b0, pmax};
    r  = rem;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r[WIDTH_W-1:0];
  endfunction

endpackage

@@ rtl/slpwm_chan.sv @@
// one pwm channel: width registers, frame ramp and level compare
`timescale 1ns / 1ps
module slpwm_chan (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  slpwm_pkg::chan_ctrl_t               ctrl_i,
  input  logic [slpwm_pkg::WIDTH_W-1:0]       max_step_i,
  input  logic [slpwm_pkg::PERIOD_W-1:0]      counter_i,
  output logic                                level_o
);
  import slpwm_pkg::*;

  logic [WIDTH_W-1:0] cur_q, cur_d;
  logic [WIDTH_W-1:0] tgt_q, tgt_d;
  logic [WIDTH_W:0]   cur_plus;
  logic [WIDTH_W:0]   tgt_plus;

  assign cur_plus = {1'b0, cur_q} + {1'b0, max_step_i};
  assign tgt_plus = {1'b0, tgt_q} + {1'b0, max_step_i};

  always_comb begin
    cur_d = cur_q;
    tgt_d = tgt_q;
    if (ctrl_i.ramp) begin
      if (cur_q < tgt_q) begin
        cur_d = (cur_plus < {1'b0, tgt_q}) ? cur_plus[WIDTH_W-1:0] : tgt_q;
      end else if (cur_q > tgt_q) begin
        cur_d = ({1'b0, cur_q} > tgt_plus) ? (cur_q - max_step_i) : tgt_q;
      end
    end
    if (ctrl_i.set_tgt) tgt_d = ctrl_i.tgt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= RST_WIDTH;
      tgt_q <= RST_WIDTH;
    end else begin
      cur_q <= cur_d;
      tgt_q <= tgt_d;
    end
  end

  assign level_o = (counter_i < {{(PERIOD_W-WIDTH_W){1'b0}}, cur_q});

endmodule

@@ rtl/slew_limited_servo_pwm_core.sv @@
// top level: multichannel servo pwm with slew-limited pulse widths
// path: an accepted request is held in the input reg, its result in the result reg
// throughput: one request per cycle; result reg and input reg both hold under back-pressure
// reset: async active low, widths and targets 1400, counter 0, outputs enabled, regs to defaults
// no memories and no clearing pass; stop can only be undone by reset
`timescale 1ns / 1ps
`include "slew_limited_servo_pwm_core_macros.svh"
module slew_limited_servo_pwm_core #(
  parameter int unsigned CHANNELS = slpwm_pkg::CHANNELS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // request stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [slpwm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [7:0] channel, [23:8] thrust
  input  logic [1:0]                             s_axis_tuser,  // [1:0] mode
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [slpwm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // [1:0] pwm_levels, [2] frame_start,
                                                                // [3] running, [7:4] zero
  // configuration writes
  input  logic                                   cfg_we_i,
  input  logic [slpwm_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [slpwm_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import slpwm_pkg::*;

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration registers
  logic [PERIOD_W-1:0] period_q;
  logic [WIDTH_W-1:0]  step_q;
  logic [WIDTH_W-1:0]  pmin_q;
  logic [WIDTH_W-1:0]  pmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= RST_PERIOD;
      step_q   <= RST_STEP;
      pmin_q   <= RST_MIN;
      pmax_q   <= RST_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PERIOD:    period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_MAX_STEP:  step_q   <= cfg_data_i[WIDTH_W-1:0];
        CFG_PULSE_MIN: pmin_q   <= cfg_data_i[WIDTH_W-1:0];
        CFG_PULSE_MAX: pmax_q   <= cfg_data_i[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake: the pipe moves when the result slot is free or being drained
  logic in_vld_q, out_vld_q;
  logic advance;
  logic s_accept;

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_vld_q;

  // input stage decode: channel reduced modulo CHANNELS by shifted compare-subtract
  logic [11:0]        chan_rem;
  logic [11:0]        chan_mul;
  logic [CH_W-1:0]    chan_idx;
  logic [WIDTH_W-1:0] tgt_new;

  always_comb begin
    chan_rem = {4'd0, s_axis_tdata[CHAN_W-1:0]};
    chan_mul = '0;
    for (int k = 7; k >= 0; k--) begin
      chan_mul = 12'(CHANNELS) << k;
      if (chan_rem >= chan_mul) chan_rem = chan_rem - chan_mul;
    end
    chan_idx = chan_rem[CH_W-1:0];
    tgt_new  = make_target(s_axis_tdata[CHAN_W +: THRUST_W], pmin_q, pmax_q);
  end

  // input register
  mode_e              mode_q;
  logic [CH_W-1:0]    idx_q;
  logic [WIDTH_W-1:0] tgt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      mode_q <= mode_e'(s_axis_tuser);
      idx_q  <= chan_idx;
      tgt_q  <= tgt_new;
    end
  end

  // work stage: counter, enable and per-channel control
  logic                process;
  logic [PERIOD_W-1:0] cnt_q, cnt_d;
  logic                en_q, en_d;
  logic [PERIOD_W:0]   cnt_inc;
  logic                wrap;
  logic                fstart;
  logic [CHANNELS-1:0] lvl;
  logic [CHANNELS+1:0] lvl_ext;
  logic [LEVELS_W-1:0] levels;
  chan_ctrl_t          ctrl [CHANNELS];

  assign process = in_vld_q && advance;
  assign cnt_inc = {1'b0, cnt_q} + 1'b1;
  // a zero period wraps on every tick, a shrunk period wraps at the next tick
  assign wrap    = (cnt_inc >= {1'b0, period_q});
  assign lvl_ext = {2'b00, lvl};

  always_comb begin
    cnt_d  = cnt_q;
    en_d   = en_q;
    fstart = 1'b0;
    levels = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      ctrl[i].set_tgt = 1'b0;
      ctrl[i].ramp    = 1'b0;
      ctrl[i].tgt     = tgt_q;
    end
    if (process) begin
      unique case (mode_q)
        MODE_TICK: begin
          // levels and frame start come from the counter before it moves
          fstart = (cnt_q == '0);
          levels = en_q ? lvl_ext[LEVELS_W-1:0] : '0;
          cnt_d  = wrap ? '0 : cnt_inc[PERIOD_W-1:0];
          for (int i = 0; i < CHANNELS; i++) ctrl[i].ramp = wrap;
        end
        MODE_SET_ONE: begin
          for (int i = 0; i < CHANNELS; i++) begin
            ctrl[i].set_tgt = (idx_q == CH_W'(i));
          end
        end
        MODE_SET_ALL: begin
          for (int i = 0; i < CHANNELS; i++) ctrl[i].set_tgt = 1'b1;
        end
        MODE_STOP: en_d = 1'b0;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    slpwm_chan u_chan (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl[g]),
      .max_step_i (step_q),
      .counter_i  (cnt_q),
      .level_o    (lvl[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      en_q  <= 1'b1;
    end else begin
      cnt_q <= cnt_d;
      en_q  <= en_d;
    end
  end

  // result register
  logic [LEVELS_W-1:0] res_lvl_q;
  logic                res_fs_q;
  logic                res_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process) begin
      res_lvl_q <= levels;
      res_fs_q  <= fstart;
      res_run_q <= en_d;
    end
  end

  assign m_axis_tdata = {4'd0, res_run_q, res_fs_q, res_lvl_q};

  // checks
  `SLPWM_ASSERT_NEXT(a_stop_sticks, clk_i, rst_ni, !en_q, !en_q)
  `SLPWM_ASSERT_IMPL(a_idle_levels, clk_i, rst_ni, out_vld_q && !res_run_q, res_lvl_q == '0)
  `SLPWM_ASSERT_NEXT(a_work_lands, clk_i, rst_ni, process, out_vld_q)
  `SLPWM_ASSERT_NEXT(a_stall_keeps, clk_i, rst_ni, in_vld_q && !advance, in_vld_q)

endmodule

@@ bench/slpwm_pulse_checker.sv @@
// request/result checker for the servo pwm core: predicts every result and compares
`timescale 1ns / 1ps
module slpwm_pulse_checker
  import slpwm_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] channel, [23:8] thrust
  input  logic [1:0]             s_axis_tuser,   // [1:0] mode
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [1:0] pwm_levels, [2] frame_start,
                                                 // [3] running, [7:4] zero
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     mismatches_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [3:0]          pad;
    logic                running;
    logic                frame_start;
    logic [LEVELS_W-1:0] levels;
  } pwm_result_t;

  // shadow registers
  logic [PERIOD_W-1:0] period_ticks;
  logic [WIDTH_W-1:0]  max_step;
  logic [WIDTH_W-1:0]  pulse_min;
  logic [WIDTH_W-1:0]  pulse_max;

  // shadow block state
  logic [PERIOD_W-1:0] frame_cnt;
  logic [WIDTH_W-1:0]  cur_width [CHANNELS];
  logic [WIDTH_W-1:0]  tgt_width [CHANNELS];
  logic                enabled;

  pwm_result_t expected_frames_q[$];
  int          mismatch_cnt = 0;

  assign mismatches_o = mismatch_cnt;

  function automatic logic [WIDTH_W-1:0] clamp_target(logic signed [THRUST_W-1:0] thrust);
    int rem;
    rem = int'(thrust) % 2048;
    if (rem < int'(pulse_min)) rem = int'(pulse_min);
    if (rem > int'(pulse_max)) rem = int'(pulse_max);
    return rem[WIDTH_W-1:0];
  endfunction

  // each width moves toward its target by at most max_step
  function automatic void ramp_widths();
    int c;
    int t;
    for (int i = 0; i < CHANNELS; i++) begin
      c = cur_width[i];
      t = tgt_width[i];
      if (c < t) begin
        c = (c + max_step < t) ? c + max_step : t;
      end else if (c > t) begin
        c = (c > t + max_step) ? c - max_step : t;
      end
      cur_width[i] = c[WIDTH_W-1:0];
    end
  endfunction

  function automatic pwm_result_t predict_frame(mode_e mode, logic [CHAN_W-1:0] chan,
                                                logic [THRUST_W-1:0] thrust);
    pwm_result_t res;
    int          nxt;
    res = '0;
    case (mode)
      MODE_TICK: begin
        res.frame_start = (frame_cnt == 0);
        if (enabled) begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (frame_cnt < cur_width[i]) res.levels[i] = 1'b1;
          end
        end
        nxt = frame_cnt + 1;
        // a zero period acts like one, a shrunk period wraps on the next tick
        if (nxt >= period_ticks) begin
          nxt = 0;
          ramp_widths();
        end
        frame_cnt = nxt[PERIOD_W-1:0];
      end
      MODE_SET_ONE: tgt_width[chan % CHANNELS] = clamp_target(thrust);
      MODE_SET_ALL: begin
        for (int i = 0; i < CHANNELS; i++) tgt_width[i] = clamp_target(thrust);
      end
      default: enabled = 1'b0;
    endcase
    res.running = enabled;
    return res;
  endfunction

  function automatic void report(string what, int exp_val, int act_val);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, exp_val, act_val);
    mismatch_cnt++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pwm_result_t exp_res;
    pwm_result_t act_res;
    if (!rst_ni) begin
      period_ticks = RST_PERIOD;
      max_step     = RST_STEP;
      pulse_min    = RST_MIN;
      pulse_max    = RST_MAX;
      frame_cnt    = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        cur_width[i] = RST_WIDTH;
        tgt_width[i] = RST_WIDTH;
      end
      enabled = 1'b1;
      expected_frames_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PERIOD:    period_ticks = cfg_data_i[PERIOD_W-1:0];
          CFG_MAX_STEP:  max_step     = cfg_data_i[WIDTH_W-1:0];
          CFG_PULSE_MIN: pulse_min    = cfg_data_i[WIDTH_W-1:0];
          default:       pulse_max    = cfg_data_i[WIDTH_W-1:0];
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act_res = m_axis_tdata;
        if (expected_frames_q.size() == 0) begin
          $display("%0t: result with no request waiting, expected none actual %0h",
                   $time, m_axis_tdata);
          mismatch_cnt++;
        end else begin
          exp_res = expected_frames_q.pop_front();
          if (act_res.levels !== exp_res.levels)
            report("pwm_levels", exp_res.levels, act_res.levels);
          if (act_res.frame_start !== exp_res.frame_start)
            report("frame_start", exp_res.frame_start, act_res.frame_start);
          if (act_res.running !== exp_res.running)
            report("running", exp_res.running, act_res.running);
          if (act_res.pad !== exp_res.pad)
            report("padding", exp_res.pad, act_res.pad);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_frames_q.push_back(predict_frame(mode_e'(s_axis_tuser),
                                                  s_axis_tdata[CHAN_W-1:0],
                                                  s_axis_tdata[CHAN_W +: THRUST_W]));
      end
      pending_o <= expected_frames_q.size();
    end
  end

endmodule

@@ bench/tb_slew_limited_servo_pwm_core.sv @@
// testbench top for the servo pwm core: stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module tb_slew_limited_servo_pwm_core;
  import slpwm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [7:0] channel, [23:8] thrust
  logic [1:0]             s_axis_tuser = '0;   // [1:0] mode
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [1:0] pwm_levels, [2] frame_start,
                                               // [3] running, [7:4] zero
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  int mismatches;
  int pending;
  int cycles = 0;

  // per-phase idling switches for the request side and the result side
  bit sender_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  int stall_left  = 0;

  always #6 clk_i = ~clk_i;

  slew_limited_servo_pwm_core u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  slpwm_pulse_checker u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // result side: ready drops in bursts of random length while stalls are on
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one request; valid stays high across back-to-back requests
  task automatic send_request(mode_e mode, logic [CHAN_W-1:0] chan,
                              logic [THRUST_W-1:0] thrust);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {thrust, chan};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait until every result is back, then let the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // write all four registers back to back; 11-bit registers get junk in the top bits
  task automatic write_config(logic [PERIOD_W-1:0] period, logic [WIDTH_W-1:0] step,
                              logic [WIDTH_W-1:0] pmin, logic [WIDTH_W-1:0] pmax);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PERIOD;
    cfg_data_i <= period;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_MAX_STEP;
    cfg_data_i <= {5'($urandom), step};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PULSE_MIN;
    cfg_data_i <= {5'($urandom), pmin};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PULSE_MAX;
    cfg_data_i <= {5'($urandom), pmax};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // mostly ticks; thrust either full random or a small remainder plus whole wraps
  task automatic random_request(bit allow_stop);
    int    pick;
    int    val;
    mode_e mode;
    pick = $urandom_range(0, 99);
    if (pick < 72)                       mode = MODE_TICK;
    else if (pick < 86)                  mode = MODE_SET_ONE;
    else if (pick < 97 || !allow_stop)   mode = MODE_SET_ALL;
    else                                 mode = MODE_STOP;
    if ($urandom_range(0, 1) == 0) begin
      val = $urandom_range(0, 60) + 2048 * $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) val = -val;
    end else begin
      val = $urandom;
    end
    send_request(mode, CHAN_W'($urandom), val[THRUST_W-1:0]);
  endtask

  initial begin
    int n_items;
    int period;
    int pmin;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, thrust extremes, channel wrap, both set modes
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    send_request(MODE_TICK,    8'hFF, 16'hFFFF);
    send_request(MODE_SET_ONE, 8'd0,  16'h7FFF);   // remainder 2047, clamped to max
    send_request(MODE_SET_ONE, 8'd255, 16'h8000);  // most negative, remainder zero
    send_request(MODE_SET_ONE, 8'd254, 16'hFFFF);  // minus one, clamped to min
    send_request(MODE_SET_ALL, 8'hA5, 16'd2048);
    send_request(MODE_SET_ALL, 8'h5A, -16'sd2048);
    send_request(MODE_SET_ALL, 8'd3,  16'd1500);
    send_request(MODE_SET_ONE, 8'd1,  16'd1999);
    send_request(MODE_SET_ONE, 8'd0,  -16'sd2047);
    send_request(MODE_SET_ONE, 8'd129, 16'd2047);
    send_request(MODE_SET_ONE, 8'd128, 16'd1001);
    repeat (8) send_request(MODE_TICK, CHAN_W'($urandom), THRUST_W'($urandom));
    drain();

    // zero period with maximum step: every tick starts a frame and widths jump
    write_config(16'd0, 11'd2047, 11'd0, 11'd2047);
    repeat (150) random_request(1'b0);
    drain();

    // period of one, zero step, crossed clamps
    sink_stalls = 1'b0;
    write_config(16'd1, 11'd0, 11'd2047, 11'd0);
    repeat (100) random_request(1'b0);
    drain();

    // longest period, the counter just climbs
    sender_gaps = 1'b0;
    sink_stalls = 1'b1;
    write_config(16'd65535, 11'd8, 11'd1000, 11'd2000);
    repeat (80) random_request(1'b0);
    drain();

    // short period below the counter: wraps on the next tick
    sender_gaps = 1'b1;
    write_config(16'd16, 11'd1, 11'd0, 11'd20);
    repeat (250) random_request(1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      bit last_phase;
      last_phase  = (ph == 5);
      sender_gaps = !last_phase && ($urandom_range(0, 3) != 0);
      sink_stalls = !last_phase && ($urandom_range(0, 3) != 0);
      period  = $urandom_range(2, 40);
      pmin    = $urandom_range(0, 15);
      write_config(PERIOD_W'(period),
                   ($urandom_range(0, 4) == 0) ? 11'd2047 : WIDTH_W'($urandom_range(0, 12)),
                   WIDTH_W'(pmin), WIDTH_W'($urandom_range(5, 45)));
      n_items = 220;
      for (int k = 0; k < n_items; k++) begin
        // stop is final, so it first comes halfway through the last phase
        if (last_phase && k == n_items / 2) begin
          send_request(MODE_STOP, CHAN_W'($urandom), THRUST_W'($urandom));
        end else begin
          random_request(last_phase && k > n_items / 2);
        end
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ slew_limited_servo_pwm_core.f @@
+incdir+rtl
rtl/slpwm_pkg.sv
rtl/slpwm_chan.sv
rtl/slew_limited_servo_pwm_core.sv
bench/slpwm_pulse_checker.sv
bench/tb_slew_limited_servo_pwm_core.sv
